// File: hdl/bqd_pkg.sv
package bqd_pkg;

    // Fixed formats of the history, the coefficients and the gain.
    localparam int HIST_WIDTH         = 40;
    localparam int HIST_FRAC_BITS     = 8;
    localparam int COEF_WIDTH         = 25;
    localparam int GAIN_WIDTH         = 24;
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam int CFG_DATA_WIDTH     = 25;
    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_FRAC_BITS = 22;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FEED_0 = 3'd0,
        CFG_FEED_1 = 3'd1,
        CFG_FEED_2 = 3'd2,
        CFG_BACK_1 = 3'd3,
        CFG_BACK_2 = 3'd4,
        CFG_GAIN   = 3'd5
    } cfg_reg_t;

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MS_BACK1_H1,
        MS_BACK2_H2,
        MS_FEED1_H1,
        MS_FEED0_W,
        MS_FEED2_H2,
        MS_GAIN_Y
    } mul_sel_t;

    // Accumulator operations.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_LOAD_P,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     take_sample;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     latch_w;
        logic     latch_y;
        logic     finish;
    } ctrl_cmd_t;

    // Current coefficient set.
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] feed_0;
        logic signed [COEF_WIDTH-1:0] feed_1;
        logic signed [COEF_WIDTH-1:0] feed_2;
        logic signed [COEF_WIDTH-1:0] back_1;
        logic signed [COEF_WIDTH-1:0] back_2;
        logic        [GAIN_WIDTH-1:0] gain;
    } coef_set_t;

endpackage

// File: hdl/biquad_iir_filter_unit.sv
// Second-order IIR filter, direct form II, on one shared multiplier.
// Input channel s_: one signed sample per word, taken when s_valid and
// s_ready are both high. Result channel m_: the filtered, normalized and
// saturated sample plus an overflow flag, which is set when the history
// value or the output saturated for that sample.
// Configuration: cfg_wr_en writes cfg_wdata into the register selected by
// cfg_index (0..2 feed-forward, 3..4 feedback, 5 inverse gain); writes to
// other indexes are ignored. Write only while no sample is in flight.
// Sequence: one sample is in flight at a time; a new sample is taken only after
// the last one has reached the output register. The six products go one after
// another through the single multiplier, between accumulator steps and
// rounding steps.
// The result sits in an output register; the block takes the next sample
// while it waits. If m_ready stays low, the next sample finishes its
// arithmetic and then holds until the output register is drained.
// Reset (aresetn low, synchronous) clears both history values, empties the
// output register and loads a unity pass-through filter at unity gain.
module biquad_iir_filter_unit #(
    parameter int SAMPLE_WIDTH   = bqd_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = bqd_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_sample_out,
    output logic                                m_overflow,
    input  logic                                cfg_wr_en,
    input  logic [bqd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bqd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
    import bqd_pkg::*;

    coef_set_t coefs;
    ctrl_cmd_t cmd;

    // Coefficient registers.
    bqd_cfg_regs #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coefs     (coefs)
    );

    // Step sequencer and handshake control.
    bqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Multiplier, accumulator, history and output register.
    bqd_datapath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sample_in  (s_sample_in),
        .cmd        (cmd),
        .coefs      (coefs),
        .sample_out (m_sample_out),
        .overflow   (m_overflow)
    );

    // Only one sample is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample accepted while another is in flight");

    // Reset leaves the block ready with an empty output register.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("block not idle after reset");

    // Finishing a sample fills the output word and frees the input.
    a_finish_hands_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (s_ready && m_valid))
        else $error("finished sample did not reach the output register");

    // A sample is never taken while the sequencer is finishing another.
    a_no_take_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.take_sample && cmd.finish))
        else $error("sample taken while finishing");

endmodule

// File: hdl/bqd_cfg_regs.sv
module bqd_cfg_regs #(
    parameter int COEF_FRAC_BITS = bqd_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bqd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [bqd_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
    output bqd_pkg::coef_set_t                   coefs
);
    import bqd_pkg::*;

    // Unity in the coefficient and gain formats.
    localparam logic [COEF_WIDTH-1:0] UNITY_COEF = COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);
    localparam logic [GAIN_WIDTH-1:0] UNITY_GAIN = GAIN_WIDTH'(64'd1 << COEF_FRAC_BITS);

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    // Decode the write; unknown indexes leave everything unchanged.
    always_comb begin
        coefs_next = coefs_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FEED_0: coefs_next.feed_0 = $signed(cfg_wdata[COEF_WIDTH-1:0]);
                CFG_FEED_1: coefs_next.feed_1 = $signed(cfg_wdata[COEF_WIDTH-1:0]);
                CFG_FEED_2: coefs_next.feed_2 = $signed(cfg_wdata[COEF_WIDTH-1:0]);
                CFG_BACK_1: coefs_next.back_1 = $signed(cfg_wdata[COEF_WIDTH-1:0]);
                CFG_BACK_2: coefs_next.back_2 = $signed(cfg_wdata[COEF_WIDTH-1:0]);
                CFG_GAIN:   coefs_next.gain   = cfg_wdata[GAIN_WIDTH-1:0];
                default:    coefs_next = coefs_reg;
            endcase
        end
    end

    // Register file; reset gives a pass-through filter at unity gain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.feed_0 <= $signed(UNITY_COEF);
            coefs_reg.feed_1 <= '0;
            coefs_reg.feed_2 <= '0;
            coefs_reg.back_1 <= '0;
            coefs_reg.back_2 <= '0;
            coefs_reg.gain   <= UNITY_GAIN;
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

// File: hdl/bqd_ctrl.sv
module bqd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output bqd_pkg::ctrl_cmd_t  cmd
);
    import bqd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B1,
        ST_B2,
        ST_W0,
        ST_W,
        ST_F0,
        ST_F2,
        ST_Y0,
        ST_Y,
        ST_G,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;

    // Step sequence: feedback sum, feed-forward sum, then gain.
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_sel     = MS_BACK1_H1;
        cmd.acc_op      = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_sample = 1'b1;
                    state_next      = ST_B1;
                end
            end
            ST_B1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BACK1_H1;
                cmd.acc_op  = ACC_LOAD_X;
                state_next  = ST_B2;
            end
            ST_B2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BACK2_H2;
                cmd.acc_op  = ACC_SUB;
                state_next  = ST_W0;
            end
            ST_W0: begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_W;
            end
            ST_W: begin
                cmd.latch_w = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_FEED1_H1;
                state_next  = ST_F0;
            end
            ST_F0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_FEED0_W;
                cmd.acc_op  = ACC_LOAD_P;
                state_next  = ST_F2;
            end
            ST_F2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_FEED2_H2;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_Y0;
            end
            ST_Y0: begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_Y;
            end
            ST_Y: begin
                cmd.latch_y = 1'b1;
                state_next  = ST_G;
            end
            ST_G: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_GAIN_Y;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output word valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

// File: hdl/bqd_datapath.sv
module bqd_datapath #(
    parameter int SAMPLE_WIDTH   = bqd_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = bqd_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  bqd_pkg::ctrl_cmd_t             cmd,
    input  bqd_pkg::coef_set_t             coefs,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           overflow
);
    import bqd_pkg::*;

    // Width of the rounded feed-forward sum, before the gain.
    localparam int Y_W   = COEF_WIDTH + HIST_WIDTH + 2 - COEF_FRAC_BITS;
    localparam int MB_W  = (Y_W > HIST_WIDTH) ? Y_W : HIST_WIDTH;
    localparam int P_W   = COEF_WIDTH + MB_W;
    localparam int XS_W  = SAMPLE_WIDTH + HIST_FRAC_BITS + COEF_FRAC_BITS + 2;
    localparam int ACC_W = (P_W + 2 > XS_W) ? P_W + 2 : XS_W;
    localparam int OUT_SHIFT = COEF_FRAC_BITS + HIST_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_OUT = ACC_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [HIST_WIDTH-1:0] HIST_MAX = {1'b0, {(HIST_WIDTH-1){1'b1}}};
    localparam logic signed [HIST_WIDTH-1:0] HIST_MIN = {1'b1, {(HIST_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [HIST_WIDTH-1:0]   hist_one_reg;
    logic signed [HIST_WIDTH-1:0]   hist_two_reg;
    logic signed [HIST_WIDTH-1:0]   w_reg;
    logic signed [HIST_WIDTH-1:0]   w_next;
    logic                           w_ovf_reg;
    logic                           w_ovf_next;
    logic signed [Y_W-1:0]          y_reg;
    logic signed [P_W-1:0]          prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [ACC_W-1:0]        acc_rnd_sum;
    logic signed [ACC_W-1:0]        acc_shift;
    logic signed [ACC_W-1:0]        out_rnd_sum;
    logic signed [ACC_W-1:0]        out_shift;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_next;
    logic                           out_ovf_next;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_ovf_reg;
    logic [ACC_W-HIST_WIDTH:0]      w_top;
    logic [ACC_W-SAMPLE_WIDTH:0]    o_top;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.mul_sel)
            MS_BACK1_H1: begin
                mul_a = coefs.back_1;
                mul_b = MB_W'(hist_one_reg);
            end
            MS_BACK2_H2: begin
                mul_a = coefs.back_2;
                mul_b = MB_W'(hist_two_reg);
            end
            MS_FEED1_H1: begin
                mul_a = coefs.feed_1;
                mul_b = MB_W'(hist_one_reg);
            end
            MS_FEED0_W: begin
                mul_a = coefs.feed_0;
                mul_b = MB_W'(w_reg);
            end
            MS_FEED2_H2: begin
                mul_a = coefs.feed_2;
                mul_b = MB_W'(hist_two_reg);
            end
            MS_GAIN_Y: begin
                mul_a = COEF_WIDTH'($signed({1'b0, coefs.gain}));
                mul_b = MB_W'(y_reg);
            end
            default: begin
                mul_a = coefs.back_1;
                mul_b = MB_W'(hist_one_reg);
            end
        endcase
    end

    // Accumulator update.
    always_comb begin
        unique case (cmd.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD_X: acc_next = ACC_W'(sample_reg) <<< (COEF_FRAC_BITS + HIST_FRAC_BITS);
            ACC_LOAD_P: acc_next = ACC_W'(prod_reg);
            ACC_ADD:    acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_SUB:    acc_next = acc_reg - ACC_W'(prod_reg);
            default:    acc_next = acc_reg;
        endcase
    end

    // Round half up and drop the coefficient fraction; saturate into history.
    always_comb begin
        acc_rnd_sum = acc_reg + HALF_ACC;
        acc_shift   = acc_rnd_sum >>> COEF_FRAC_BITS;
        w_top       = acc_shift[ACC_W-1:HIST_WIDTH-1];
        w_ovf_next  = !((&w_top) || !(|w_top));
        if (w_ovf_next) begin
            w_next = acc_shift[ACC_W-1] ? HIST_MIN : HIST_MAX;
        end else begin
            w_next = acc_shift[HIST_WIDTH-1:0];
        end
    end

    // Scale by the gain product, round, and saturate to the sample width.
    always_comb begin
        out_rnd_sum  = ACC_W'(prod_reg) + HALF_OUT;
        out_shift    = out_rnd_sum >>> OUT_SHIFT;
        o_top        = out_shift[ACC_W-1:SAMPLE_WIDTH-1];
        out_ovf_next = !((&o_top) || !(|o_top));
        if (out_ovf_next) begin
            out_sample_next = out_shift[ACC_W-1] ? SAMP_MIN : SAMP_MAX;
        end else begin
            out_sample_next = out_shift[SAMPLE_WIDTH-1:0];
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (cmd.take_sample) begin
            sample_reg <= sample_in;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        acc_reg <= acc_next;
        if (cmd.latch_w) begin
            w_reg <= w_next;
        end
        if (cmd.latch_y) begin
            y_reg <= acc_shift[Y_W-1:0];
        end
        if (cmd.finish) begin
            out_sample_reg <= out_sample_next;
            out_ovf_reg    <= out_ovf_next || w_ovf_reg;
        end
    end

    // Filter state and the history saturation flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_one_reg <= '0;
            hist_two_reg <= '0;
            w_ovf_reg    <= 1'b0;
        end else begin
            if (cmd.latch_w) begin
                w_ovf_reg <= w_ovf_next;
            end
            if (cmd.finish) begin
                hist_two_reg <= hist_one_reg;
                hist_one_reg <= w_reg;
            end
        end
    end

    assign sample_out = out_sample_reg;
    assign overflow   = out_ovf_reg;

endmodule
